// File: rtl/tis_pkg.sv
package tis_pkg;

  localparam int unsigned ACC_BITS_DEFAULT = 64;
  localparam int unsigned ACC_BITS_MIN     = 8;
  localparam int unsigned ACC_BITS_MAX     = 64;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned WLEFT_W   = 9;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_AW;

  // bit 8 of the width counter marks an unlimited field
  localparam logic [WLEFT_W-1:0] NO_LIMIT = 9'h100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_MODE    = 2'd0,
    CFG_FIELD_LIMIT  = 2'd1,
    CFG_RESULT_SIGN  = 2'd2,
    CFG_RESULT_WSEL  = 2'd3
  } tis_cfg_idx_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } tis_base_e;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2,
    WSEL_64 = 2'd3
  } tis_wsel_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY  = 2'd0,
    ST_OK    = 2'd1,
    ST_NODIG = 2'd2,
    ST_FAIL  = 2'd3
  } tis_status_e;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_PREFIX = 3'd2,
    PH_ZERO   = 3'd3,
    PH_DIGITS = 3'd4
  } tis_phase_e;

  typedef struct packed {
    tis_base_e             base;
    logic [CHAR_W-1:0]     field_limit;
    logic                  res_signed;
    tis_wsel_e             wsel;
  } tis_cfg_t;

  // character after classification; all flags but eoi are low on end of input
  typedef struct packed {
    logic                  eoi;
    logic                  is_space;
    logic                  is_plus;
    logic                  is_minus;
    logic                  is_zero;
    logic                  is_x;
    logic                  is_b;
    logic                  dig_valid;
    logic [DIGIT_W-1:0]    dig;
  } tis_item_t;

  typedef struct packed {
    tis_status_e           status;
    logic [VALUE_W-1:0]    value;
    logic                  char_taken;
    logic [COUNT_W-1:0]    chars_count;
  } tis_result_t;

endpackage

// File: rtl/tis_in_if.sv
interface tis_in_if;
  import tis_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

// File: rtl/tis_out_if.sv
interface tis_out_if;
  import tis_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value;
  logic                char_taken;
  logic [COUNT_W-1:0]  chars_count;

  modport source (output valid, output status, output value, output char_taken,
                  output chars_count, input ready);
  modport sink   (input valid, input status, input value, input char_taken,
                  input chars_count, output ready);
endinterface

// File: rtl/tis_front.sv
module tis_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [tis_pkg::CHAR_W-1:0] char_code_i,
  input  logic                     end_of_input_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output tis_pkg::tis_item_t       q_item_o
);
  import tis_pkg::*;

  logic      valid_q, valid_d;
  tis_item_t item_q, item_d;
  logic      accept;

  function automatic tis_item_t classify(input logic [CHAR_W-1:0] c, input logic eoi);
    tis_item_t it;
    logic      live;
    it       = '0;
    live     = !eoi;
    it.eoi   = eoi;
    it.is_space = live && (c == 8'h20 || c == 8'h0c || c == 8'h0a ||
                           c == 8'h0d || c == 8'h09 || c == 8'h0b);
    it.is_plus  = live && (c == 8'h2b);
    it.is_minus = live && (c == 8'h2d);
    it.is_zero  = live && (c == 8'h30);
    it.is_x     = live && (c == 8'h78 || c == 8'h58);
    it.is_b     = live && (c == 8'h62 || c == 8'h42);
    if (live && c >= 8'h30 && c <= 8'h39) begin
      it.dig_valid = 1'b1;
      it.dig       = DIGIT_W'(c - 8'h30);
    end else if (live && c >= 8'h61 && c <= 8'h7a) begin
      it.dig_valid = 1'b1;
      it.dig       = DIGIT_W'(c - 8'h57);
    end else if (live && c >= 8'h41 && c <= 8'h5a) begin
      it.dig_valid = 1'b1;
      it.dig       = DIGIT_W'(c - 8'h37);
    end
    return it;
  endfunction

  assign q_push_o   = valid_q && !q_full_i;
  assign in_ready_o = !valid_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d = 1'b1;
      item_d  = classify(char_code_i, end_of_input_i);
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end
endmodule

// File: rtl/tis_queue.sv
module tis_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tis_pkg::tis_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tis_pkg::tis_item_t item_o
);
  import tis_pkg::*;

  tis_item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]       count_q, count_d;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end
endmodule

// File: rtl/tis_back.sv
module tis_back #(
  parameter int unsigned ACC_BITS = tis_pkg::ACC_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tis_pkg::tis_cfg_t    cfg_i,
  input  logic                 q_valid_i,
  input  tis_pkg::tis_item_t   q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tis_pkg::tis_result_t out_res_o
);
  import tis_pkg::*;

  tis_phase_e           phase_q, phase_d;
  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic [ACC_BITS-1:0]  nacc_q, nacc_d;   // tracks the two's complement of acc
  logic                 neg_q, neg_d;
  logic [WLEFT_W-1:0]   wl_q, wl_d;
  logic                 seen_q, seen_d;
  logic [COUNT_W-1:0]   cnt_q, cnt_d;

  logic                 out_valid_q;
  tis_result_t          res_q, res_d;
  logic                 load;

  logic [ACC_BITS-1:0]  acc_scaled, nacc_scaled, acc_step, nacc_step, dig_ext;
  logic [RADIX_W-1:0]   rdx;
  logic                 is_hex, is_bin, dig_ok;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] n);
    return (n == '1) ? n : n + 1'b1;
  endfunction

  function automatic logic [WLEFT_W-1:0] use_width(input logic [WLEFT_W-1:0] w);
    return (!w[WLEFT_W-1] && w != '0) ? w - 1'b1 : w;
  endfunction

  function automatic logic width_gone(input logic [WLEFT_W-1:0] w);
    return !w[WLEFT_W-1] && (w == '0);
  endfunction

  // multiply by the radix with shifts and adds
  function automatic logic [ACC_BITS-1:0] scale(input logic [ACC_BITS-1:0] a,
                                                input tis_base_e b);
    logic [ACC_BITS-1:0] r;
    unique case (b)
      BASE_DEC: r = (a << 3) + (a << 1);
      BASE_HEX: r = a << 4;
      BASE_OCT: r = a << 3;
      BASE_BIN: r = a << 1;
      default:  r = a;
    endcase
    return r;
  endfunction

  always_comb begin
    unique case (cfg_i.base)
      BASE_DEC: rdx = 5'd10;
      BASE_HEX: rdx = 5'd16;
      BASE_OCT: rdx = 5'd8;
      BASE_BIN: rdx = 5'd2;
      default:  rdx = 5'd10;
    endcase
  end

  assign is_hex      = (cfg_i.base == BASE_HEX);
  assign is_bin      = (cfg_i.base == BASE_BIN);
  assign dig_ok      = q_item_i.dig_valid && (q_item_i.dig < {1'b0, rdx});
  assign dig_ext     = ACC_BITS'(q_item_i.dig);
  assign acc_scaled  = scale(acc_q, cfg_i.base);
  assign nacc_scaled = scale(nacc_q, cfg_i.base);
  assign acc_step    = acc_scaled + dig_ext;
  assign nacc_step   = nacc_scaled - dig_ext;

  // conversion step for the item at the head of the queue
  always_comb begin
    tis_item_t           it;
    logic                busy;
    logic [VALUE_W-1:0]  raw;
    logic                sgn;
    logic [VALUE_W-1:0]  ext;

    it      = q_item_i;
    busy    = 1'b1;
    phase_d = phase_q;
    acc_d   = acc_q;
    nacc_d  = nacc_q;
    neg_d   = neg_q;
    wl_d    = wl_q;
    seen_d  = seen_q;
    cnt_d   = cnt_q;
    res_d.status     = ST_BUSY;
    res_d.char_taken = 1'b0;
    res_d.value      = '0;

    if (phase_d == PH_SPACE) begin
      if (it.eoi) begin
        res_d.status = ST_FAIL;
        busy = 1'b0;
      end else if (it.is_space) begin
        cnt_d = sat_inc(cnt_d);
        res_d.char_taken = 1'b1;
        busy = 1'b0;
      end else begin
        wl_d = (cfg_i.field_limit != '0) ? {1'b0, cfg_i.field_limit} : NO_LIMIT;
        phase_d = PH_SIGN;
      end
    end

    if (busy && phase_d == PH_SIGN) begin
      if (it.eoi) begin
        res_d.status = ST_FAIL;
        busy = 1'b0;
      end else if (it.is_plus || it.is_minus) begin
        neg_d = it.is_minus;
        cnt_d = sat_inc(cnt_d);
        wl_d  = use_width(wl_d);
        res_d.char_taken = 1'b1;
        busy = 1'b0;
      end
      // the sign alone used up the field
      if (!it.eoi && (it.is_plus || it.is_minus) && width_gone(wl_d)) begin
        res_d.status = ST_FAIL;
      end else if (!it.eoi) begin
        phase_d = ((is_hex || is_bin) && (wl_d[WLEFT_W-1] || wl_d >= WLEFT_W'(3)))
                  ? PH_PREFIX : PH_DIGITS;
      end
    end

    if (busy && phase_d == PH_PREFIX) begin
      if (it.eoi) begin
        res_d.status = ST_FAIL;
        busy = 1'b0;
      end else if (it.is_zero) begin
        cnt_d  = sat_inc(cnt_d);
        wl_d   = use_width(wl_d);
        res_d.char_taken = 1'b1;
        busy   = 1'b0;
        acc_d  = '0;
        nacc_d = '0;
        seen_d = 1'b1;
        phase_d = PH_ZERO;
      end else begin
        phase_d = PH_DIGITS;
      end
    end

    if (busy && phase_d == PH_ZERO) begin
      phase_d = PH_DIGITS;
      if ((is_hex && it.is_x) || (is_bin && it.is_b)) begin
        cnt_d  = sat_inc(cnt_d);
        wl_d   = use_width(wl_d);
        res_d.char_taken = 1'b1;
        busy   = 1'b0;
        seen_d = 1'b0;
        acc_d  = '0;
        nacc_d = '0;
      end
    end

    if (busy && phase_d == PH_DIGITS) begin
      if (dig_ok) begin
        acc_d  = acc_step;
        nacc_d = nacc_step;
        seen_d = 1'b1;
        cnt_d  = sat_inc(cnt_d);
        wl_d   = use_width(wl_d);
        res_d.char_taken = 1'b1;
        if (width_gone(wl_d)) begin
          res_d.status = ST_OK;
        end
      end else begin
        res_d.status = seen_d ? ST_OK : ST_NODIG;
      end
    end

    raw = neg_d ? VALUE_W'(nacc_d) : VALUE_W'(acc_d);
    unique case (cfg_i.wsel)
      WSEL_8: begin
        sgn = cfg_i.res_signed && raw[7];
        ext = {{(VALUE_W-8){sgn}}, raw[7:0]};
      end
      WSEL_16: begin
        sgn = cfg_i.res_signed && raw[15];
        ext = {{(VALUE_W-16){sgn}}, raw[15:0]};
      end
      WSEL_32: begin
        sgn = cfg_i.res_signed && raw[31];
        ext = {{(VALUE_W-32){sgn}}, raw[31:0]};
      end
      default: begin
        sgn = 1'b0;
        ext = raw;
      end
    endcase
    if (res_d.status == ST_OK) begin
      res_d.value = ext;
    end
    res_d.chars_count = cnt_d;

    // a finished conversion starts the next one from scratch
    if (res_d.status != ST_BUSY) begin
      phase_d = PH_SPACE;
      acc_d   = '0;
      nacc_d  = '0;
      neg_d   = 1'b0;
      wl_d    = '0;
      seen_d  = 1'b0;
      cnt_d   = '0;
    end
  end

  // handshake: advance when the output register is free or being drained
  always_comb begin
    load    = !out_valid_q || out_ready_i;
    q_pop_o = q_valid_i && load;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      acc_q       <= '0;
      nacc_q      <= '0;
      neg_q       <= 1'b0;
      wl_q        <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= q_valid_i;
      end
      if (q_pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        nacc_q  <= nacc_d;
        neg_q   <= neg_d;
        wl_q    <= wl_d;
        seen_q  <= seen_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end
endmodule

// File: rtl/text_integer_scanner.sv
// channel | direction | beat payload
// --------+-----------+----------------------------------------------
// in_i    | sink      | char_code[7:0], end_of_input
// out_o   | source    | status[1:0], value[63:0], char_taken, chars_count[15:0]
// cfg     | write     | cfg_we_i, cfg_idx_i[1:0], cfg_data_i[7:0]
//
// One character per cycle sustained while out_o is not stalled; a result passes the front
// register, the two-entry queue and the result register after its character is accepted.
// The digit accumulate (shift-and-add by the radix) sets the per-cycle work.
// rst_ni clears the conversion state, the queue and restores register defaults.
// A stalled output fills the queue, then drops in_i.ready; each side stalls alone.
module text_integer_scanner #(
  parameter int unsigned ACC_BITS = tis_pkg::ACC_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tis_in_if.sink                         in_i,
  tis_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tis_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tis_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tis_pkg::*;

  tis_cfg_t    cfg_q, cfg_d;
  logic        q_full, q_push, q_valid, q_pop;
  tis_item_t   push_item, head_item;
  tis_result_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tis_cfg_idx_e'(cfg_idx_i))
        CFG_BASE_MODE:   cfg_d.base        = tis_base_e'(cfg_data_i[1:0]);
        CFG_FIELD_LIMIT: cfg_d.field_limit = cfg_data_i;
        CFG_RESULT_SIGN: cfg_d.res_signed  = cfg_data_i[0];
        CFG_RESULT_WSEL: cfg_d.wsel        = tis_wsel_e'(cfg_data_i[1:0]);
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base        <= BASE_DEC;
      cfg_q.field_limit <= '0;
      cfg_q.res_signed  <= 1'b1;
      cfg_q.wsel        <= WSEL_32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tis_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .char_code_i    (in_i.char_code),
    .end_of_input_i (in_i.end_of_input),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  tis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tis_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.status      = res.status;
  assign out_o.value       = res.value;
  assign out_o.char_taken  = res.char_taken;
  assign out_o.chars_count = res.chars_count;
endmodule

// File: rtl/tis_checker.sv
module tis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tis_pkg::STATUS_W-1:0]  out_status_i,
  input logic [tis_pkg::VALUE_W-1:0]   out_value_i,
  input logic                          out_char_taken_i
);
  import tis_pkg::*;

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_status_i))
    else $error("result beat changed while stalled");

  // only a converted field carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_value_i == '0)
    else $error("value present without a completed conversion");

  // a pushed-back character always ends the conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_char_taken_i |-> out_status_i != ST_BUSY)
    else $error("character pushed back while conversion still in progress");
endmodule

bind text_integer_scanner tis_checker u_tis_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_status_i     (out_o.status),
  .out_value_i      (out_o.value),
  .out_char_taken_i (out_o.char_taken)
);

// File: tb/sv/text_integer_scanner_tb.sv
`timescale 1ns / 1ps

module text_integer_scanner_tb;
  import tis_pkg::*;

  typedef struct packed {
    logic       eoi;
    logic [7:0] chr;
  } scan_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_vld = 1'b0;
  logic [7:0] in_chr = 8'h00;
  logic       in_eoi = 1'b0;
  logic       out_rdy = 1'b0;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_dat = '0;

  tis_in_if  in_if ();
  tis_out_if out_if ();

  assign in_if.valid        = in_vld;
  assign in_if.char_code    = in_chr;
  assign in_if.end_of_input = in_eoi;
  assign out_if.ready       = out_rdy;

  text_integer_scanner uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_dat)
  );

  always #5 clk = ~clk;

  // pending characters and expected conversion results
  scan_beat_t  char_q[$];
  tis_result_t expected_q[$];
  scan_beat_t  next_beat;
  logic        in_took = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int          err_cnt = 0;

  logic [7:0] ws_chars [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  logic [7:0] limit_set [10] = '{8'd0, 8'd255, 8'd3, 8'd0, 8'd2,
                                 8'd1, 8'd0, 8'd12, 8'd0, 8'd4};

  // scanner registers as last written
  tis_base_e  base_q = BASE_DEC;
  logic [7:0] limit_q = 8'd0;
  logic       sign_ext_q = 1'b1;
  tis_wsel_e  wsel_q = WSEL_32;

  // conversion state
  tis_phase_e  ph = PH_SPACE;
  logic [63:0] acc = '0;
  logic        neg = 1'b0;
  logic [8:0]  wleft = '0;
  logic        dig_seen = 1'b0;
  logic [15:0] ccount = '0;

  function automatic int unsigned radix_of(tis_base_e b);
    case (b)
      BASE_HEX: return 16;
      BASE_OCT: return 8;
      BASE_BIN: return 2;
      default:  return 10;
    endcase
  endfunction

  function automatic void take_char();
    if (ccount != 16'hFFFF) ccount++;
  endfunction

  function automatic void use_width();
    if (!wleft[8] && wleft != 0) wleft--;
  endfunction

  function automatic logic width_gone();
    return !wleft[8] && wleft == 0;
  endfunction

  function automatic tis_phase_e phase_after_sign();
    int unsigned rdx;
    rdx = radix_of(base_q);
    if ((rdx == 16 || rdx == 2) && (wleft[8] || wleft >= 3)) return PH_PREFIX;
    return PH_DIGITS;
  endfunction

  function automatic tis_result_t predict_beat(logic [7:0] c, logic eoi);
    tis_result_t r;
    int unsigned rdx, d, w;
    logic        busy;
    logic [63:0] v, m;
    r = '0;
    r.status = ST_BUSY;
    busy = 1'b1;
    rdx = radix_of(base_q);

    if (ph == PH_SPACE) begin
      if (eoi) begin
        r.status = ST_FAIL;
        busy = 1'b0;
      end else if (c inside {8'h20, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b}) begin
        take_char();
        r.char_taken = 1'b1;
        busy = 1'b0;
      end else begin
        // field width is latched at the first non-space character
        wleft = (limit_q != 0) ? {1'b0, limit_q} : NO_LIMIT;
        ph = PH_SIGN;
      end
    end
    if (busy && ph == PH_SIGN) begin
      if (eoi) begin
        r.status = ST_FAIL;
        busy = 1'b0;
      end else if (c == "-" || c == "+") begin
        neg = (c == "-");
        take_char();
        use_width();
        r.char_taken = 1'b1;
        busy = 1'b0;
        if (width_gone()) r.status = ST_FAIL;
        else ph = phase_after_sign();
      end else begin
        ph = phase_after_sign();
      end
    end
    if (busy && ph == PH_PREFIX) begin
      if (eoi) begin
        r.status = ST_FAIL;
        busy = 1'b0;
      end else if (c == "0") begin
        take_char();
        use_width();
        r.char_taken = 1'b1;
        busy = 1'b0;
        acc = '0;
        dig_seen = 1'b1;
        ph = PH_ZERO;
      end else begin
        ph = PH_DIGITS;
      end
    end
    if (busy && ph == PH_ZERO) begin
      ph = PH_DIGITS;
      if (!eoi && ((rdx == 16 && (c == "x" || c == "X")) ||
                   (rdx == 2 && (c == "b" || c == "B")))) begin
        take_char();
        use_width();
        r.char_taken = 1'b1;
        busy = 1'b0;
        dig_seen = 1'b0;
        acc = '0;
      end
    end
    if (busy && ph == PH_DIGITS) begin
      if (eoi) d = 99;
      else if (c >= "0" && c <= "9") d = int'(c - "0");
      else if (c >= "a" && c <= "z") d = int'(c - "a") + 10;
      else if (c >= "A" && c <= "Z") d = int'(c - "A") + 10;
      else d = 99;
      if (d < rdx) begin
        acc = acc * rdx + d;
        dig_seen = 1'b1;
        take_char();
        use_width();
        r.char_taken = 1'b1;
        if (width_gone()) r.status = ST_OK;
      end else begin
        r.status = dig_seen ? ST_OK : ST_NODIG;
      end
    end

    if (r.status == ST_OK) begin
      v = neg ? (64'd0 - acc) : acc;
      w = 8 << wsel_q;
      if (w < 64) begin
        m = (64'd1 << w) - 64'd1;
        v &= m;
        if (sign_ext_q && v[w-1]) v |= ~m;
      end
      r.value = v;
    end
    r.chars_count = ccount;
    if (r.status != ST_BUSY) begin
      ph = PH_SPACE;
      acc = '0;
      neg = 1'b0;
      wleft = '0;
      dig_seen = 1'b0;
      ccount = '0;
    end
    return r;
  endfunction

  function automatic void flag_error(string msg);
    if (err_cnt < 10) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endfunction

  // driver: new beat only once the current one is gone
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_vld || in_took) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_beat = char_q.pop_front();
          in_vld <= 1'b1;
          in_chr <= next_beat.chr;
          in_eoi <= next_beat.eoi;
        end else begin
          in_vld <= 1'b0;
        end
      end
      out_rdy <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // monitor: predict on every accepted character, check every result beat
  always @(posedge clk) begin
    tis_result_t want;
    in_took <= in_vld && in_if.ready;
    if (rst_n) begin
      if (in_vld && in_if.ready) expected_q.push_back(predict_beat(in_chr, in_eoi));
      if (out_if.valid && out_rdy) begin
        if (expected_q.size() == 0) begin
          flag_error($sformatf("result with none expected: status %0d value %h",
                               out_if.status, out_if.value));
        end else begin
          want = expected_q.pop_front();
          if (out_if.status !== want.status)
            flag_error($sformatf("status exp %0d got %0d", want.status, out_if.status));
          if (out_if.value !== want.value)
            flag_error($sformatf("value exp %h got %h", want.value, out_if.value));
          if (out_if.char_taken !== want.char_taken)
            flag_error($sformatf("char_taken exp %0b got %0b",
                                 want.char_taken, out_if.char_taken));
          if (out_if.chars_count !== want.chars_count)
            flag_error($sformatf("chars_count exp %0d got %0d",
                                 want.chars_count, out_if.chars_count));
        end
      end
    end
  end

  task automatic push_beat(logic [7:0] c, logic eoi);
    char_q.push_back({eoi, c});
  endtask

  // whitespace, sign, prefix, digits of the current radix, terminator; each part may be absent
  task automatic push_number();
    int unsigned rdx, n, d;
    logic [7:0]  lc;
    rdx = radix_of(base_q);
    repeat ($urandom_range(0, 2)) push_beat(ws_chars[$urandom_range(0, 5)], 1'b0);
    case ($urandom_range(0, 3))
      1: push_beat("+", 1'b0);
      2: push_beat("-", 1'b0);
      default: ;
    endcase
    if ((rdx == 16 || rdx == 2) && $urandom_range(0, 1)) begin
      lc = (rdx == 16) ? "x" : "b";
      // now and then the other radix letter
      if ($urandom_range(0, 7) == 0) lc = (rdx == 16) ? "b" : "x";
      push_beat("0", 1'b0);
      push_beat($urandom_range(0, 1) ? lc : lc - 8'h20, 1'b0);
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 6);
    repeat (n) begin
      d = $urandom_range(0, rdx - 1);
      if (d < 10) push_beat(8'(8'h30 + d), 1'b0);
      else push_beat(8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10), 1'b0);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_beat(ws_chars[$urandom_range(0, 5)], 1'b0);
      4, 5:       push_beat(8'($urandom_range(0, 255)), 1'b1);
      6, 7:       push_beat(8'($urandom_range(0, 255)), 1'b0);
      default:    ;
    endcase
  endtask

  // hold stimulus until the scanner has nothing in flight
  task automatic drain_scanner();
    do begin
      @(posedge clk);
      #1;
    end while (char_q.size() != 0 || in_vld || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(tis_cfg_idx_e idx, logic [7:0] data);
    @(negedge clk);
    cfg_we  <= 1'b1;
    cfg_idx <= idx;
    cfg_dat <= data;
    case (idx)
      CFG_BASE_MODE:   base_q = tis_base_e'(data[1:0]);
      CFG_FIELD_LIMIT: limit_q = data;
      CFG_RESULT_SIGN: sign_ext_q = data[0];
      CFG_RESULT_WSEL: wsel_q = tis_wsel_e'(data[1:0]);
      default: ;
    endcase
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: default registers, decimal, signed 32-bit
    push_beat(8'h00, 1'b1);
    foreach (ws_chars[i]) push_beat(ws_chars[i], 1'b0);
    push_beat("-", 1'b0);
    push_beat("1", 1'b0);
    push_beat("2", 1'b0);
    push_beat("8", 1'b0);
    push_beat(8'hFF, 1'b1);
    push_beat("+", 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat("0", 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat("9", 1'b0);
    push_beat(";", 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);

    for (int p = 0; p < 10; p++) begin
      drain_scanner();
      write_reg(CFG_BASE_MODE, 8'(p % 4));
      write_reg(CFG_FIELD_LIMIT, limit_set[p]);
      write_reg(CFG_RESULT_SIGN, 8'((p >> 1) & 1));
      write_reg(CFG_RESULT_WSEL, 8'((p / 4 + p) % 4));
      @(negedge clk);
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      while (char_q.size() < 150) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4))
            push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end else begin
          push_number();
        end
      end
    end

    drain_scanner();
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
